// ===== rtl/nscf_pkg.sv =====
`default_nettype none

package nscf_pkg;

    // character codes the framer reacts to
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_CR     = 8'h0D;
    localparam logic [7:0] CHAR_LF     = 8'h0A;

    // sentence kind codes
    localparam logic [2:0] KIND_OTHER = 3'd0;
    localparam logic [2:0] KIND_RMC   = 3'd1;
    localparam logic [2:0] KIND_GGA   = 3'd2;
    localparam logic [2:0] KIND_GSA   = 3'd3;
    localparam logic [2:0] KIND_GSV   = 3'd4;
    localparam logic [2:0] KIND_TXT   = 3'd5;
    localparam logic [2:0] KIND_GLL   = 3'd6;
    localparam logic [2:0] KIND_VTG   = 3'd7;

    // tag letters packed high to low
    localparam logic [23:0] TAG_RMC = {8'h52, 8'h4D, 8'h43};
    localparam logic [23:0] TAG_GGA = {8'h47, 8'h47, 8'h41};
    localparam logic [23:0] TAG_GSA = {8'h47, 8'h53, 8'h41};
    localparam logic [23:0] TAG_GSV = {8'h47, 8'h53, 8'h56};
    localparam logic [23:0] TAG_TXT = {8'h54, 8'h58, 8'h54};
    localparam logic [23:0] TAG_GLL = {8'h47, 8'h4C, 8'h4C};
    localparam logic [23:0] TAG_VTG = {8'h56, 8'h54, 8'h47};

    // one framed sentence summary
    typedef struct packed {
        logic       sum_ok;
        logic [2:0] kind;
        logic [7:0] sum;
        logic [6:0] len;
    } res_t;

    // hex digit decode: bit 4 set when the character is a hex digit
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c inside {[8'h30:8'h39]})
        begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end
        else if (c inside {[8'h41:8'h46]})
        begin
            v = c - 8'h37;
            return {1'b1, v[3:0]};
        end
        else if (c inside {[8'h61:8'h66]})
        begin
            v = c - 8'h57;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    // tag letters to sentence kind
    function automatic logic [2:0] kind_lookup(input logic [23:0] tag);
        logic [2:0] k;
        case (tag)
            TAG_RMC: k = KIND_RMC;
            TAG_GGA: k = KIND_GGA;
            TAG_GSA: k = KIND_GSA;
            TAG_GSV: k = KIND_GSV;
            TAG_TXT: k = KIND_TXT;
            TAG_GLL: k = KIND_GLL;
            TAG_VTG: k = KIND_VTG;
            default: k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nmea_sentence_checksum_framer_unit.sv =====
// path: after its CR or LF transfer a result passes the input register, then the result
// register, before the receiver can take it
// throughput: one character per cycle; a line end waits only while the previous result
// is still held by a stalled receiver
// reset: rst_n clears both valid flags and the open sentence; payload registers keep data
`default_nettype none

module nmea_sentence_checksum_framer_unit #(
    parameter int BUFFER_BYTES = 128
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_char,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            sum_ok,
    output logic [2:0]      sentence_kind,
    output logic [7:0]      computed_sum,
    output logic [6:0]      kept_length
);
    import nscf_pkg::*;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic       advance;
    logic       line_end;
    logic       load;
    logic       in_take;
    res_t       res;

    // a character moves on unless its result has nowhere to go
    assign advance  = in_valid_reg && (!line_end || !out_valid || !out_stall);
    assign load     = advance && line_end;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        else
        begin
            in_valid_next = in_valid_reg;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= rx_char;
        end
    end

    nscf_framer #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_framer (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .ch       (char_reg),
        .res      (res),
        .line_end (line_end)
    );

    nscf_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (load),
        .res           (res),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .sum_ok        (sum_ok),
        .sentence_kind (sentence_kind),
        .computed_sum  (computed_sum),
        .kept_length   (kept_length)
    );

    // an empty input register never holds off the sender
    assert property (@(posedge clk) disable iff (!rst_n) !in_valid_reg |-> !in_stall)
        else $error("input stalled while empty");

    // a new result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n) load |-> (!out_valid || !out_stall))
        else $error("result register overrun");

    // a sentence kind is only reported with a good checksum
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !sum_ok) |-> (sentence_kind == KIND_OTHER))
        else $error("kind reported without valid sum");

    // a result always covers at least the dollar sign
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (kept_length != 7'd0))
        else $error("empty sentence reported");

endmodule

`default_nettype wire

// ===== rtl/nscf_framer.sv =====
`default_nettype none

module nscf_framer #(
    parameter int BUFFER_BYTES = 128
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire logic [7:0]     ch,
    output nscf_pkg::res_t      res,
    output logic                line_end
);
    import nscf_pkg::*;

    localparam int FILL_W = $clog2(BUFFER_BYTES);
    localparam logic [FILL_W-1:0] FILL_LIMIT = FILL_W'(BUFFER_BYTES - 1);

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic              star_reg, star_next;
    logic [7:0]        xor_reg, xor_next;
    logic [1:0]        hex_cnt_reg, hex_cnt_next;
    logic              hex_bad_reg, hex_bad_next;
    logic [7:0]        rsum_reg, rsum_next;
    logic [23:0]       tag_reg, tag_next;
    logic              tag_early_reg, tag_early_next;

    logic       is_dollar, is_eol, keep;
    logic [4:0] hex;
    logic       ok;

    assign is_dollar = (ch == CHAR_DOLLAR);
    assign is_eol    = (ch == CHAR_CR) || (ch == CHAR_LF);
    assign line_end  = is_eol && (fill_reg != '0);
    assign keep      = (fill_reg != '0) && (fill_reg < FILL_LIMIT);
    assign hex       = hex_decode(ch);

    // checksum verdict and result fields
    always_comb
    begin
        ok = star_reg && (hex_cnt_reg == 2'd2) && !hex_bad_reg
            && (rsum_reg == xor_reg) && (fill_reg >= FILL_W'(4));
        res.sum_ok = ok;
        res.sum    = xor_reg;
        res.kind   = KIND_OTHER;
        if (ok && (fill_reg >= FILL_W'(6)) && !tag_early_reg)
        begin
            res.kind = kind_lookup(tag_reg);
        end
        if (fill_reg > FILL_W'(127))
        begin
            res.len = 7'd127;
        end
        else
        begin
            res.len = 7'(fill_reg);
        end
    end

    // per-character state update
    always_comb
    begin
        fill_next      = fill_reg;
        star_next      = star_reg;
        xor_next       = xor_reg;
        hex_cnt_next   = hex_cnt_reg;
        hex_bad_next   = hex_bad_reg;
        rsum_next      = rsum_reg;
        tag_next       = tag_reg;
        tag_early_next = tag_early_reg;
        if (is_dollar || is_eol)
        begin
            fill_next      = '0;
            star_next      = 1'b0;
            xor_next       = 8'd0;
            hex_cnt_next   = 2'd0;
            hex_bad_next   = 1'b0;
            rsum_next      = 8'd0;
            tag_next       = 24'd0;
            tag_early_next = 1'b0;
            if (is_dollar)
            begin
                fill_next = FILL_W'(1);
            end
        end
        else if (keep)
        begin
            fill_next = fill_reg + FILL_W'(1);
            if ((fill_reg >= FILL_W'(1)) && (fill_reg <= FILL_W'(5))
                && ((ch == CHAR_COMMA) || (ch == CHAR_STAR) || (ch == CHAR_NUL)))
            begin
                tag_early_next = 1'b1;
            end
            if (fill_reg == FILL_W'(3))
            begin
                tag_next[23:16] = ch;
            end
            if (fill_reg == FILL_W'(4))
            begin
                tag_next[15:8] = ch;
            end
            if (fill_reg == FILL_W'(5))
            begin
                tag_next[7:0] = ch;
            end
            if (!star_reg)
            begin
                if (ch == CHAR_STAR)
                begin
                    star_next = 1'b1;
                end
                else
                begin
                    xor_next = xor_reg ^ ch;
                end
            end
            else if (hex_cnt_reg < 2'd2)
            begin
                if (!hex[4])
                begin
                    hex_bad_next = 1'b1;
                end
                else
                begin
                    rsum_next = {rsum_reg[3:0], hex[3:0]};
                end
                hex_cnt_next = hex_cnt_reg + 2'd1;
            end
        end
    end

    // sentence state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            star_reg      <= 1'b0;
            xor_reg       <= 8'd0;
            hex_cnt_reg   <= 2'd0;
            hex_bad_reg   <= 1'b0;
            rsum_reg      <= 8'd0;
            tag_reg       <= 24'd0;
            tag_early_reg <= 1'b0;
        end
        else if (step)
        begin
            fill_reg      <= fill_next;
            star_reg      <= star_next;
            xor_reg       <= xor_next;
            hex_cnt_reg   <= hex_cnt_next;
            hex_bad_reg   <= hex_bad_next;
            rsum_reg      <= rsum_next;
            tag_reg       <= tag_next;
            tag_early_reg <= tag_early_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nscf_out_reg.sv =====
`default_nettype none

module nscf_out_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire nscf_pkg::res_t res,
    input  wire logic           out_stall,
    output logic                out_valid,
    output logic                sum_ok,
    output logic [2:0]          sentence_kind,
    output logic [7:0]          computed_sum,
    output logic [6:0]          kept_length
);
    import nscf_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    // hold the result until the transfer completes
    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid     = valid_reg;
    assign sum_ok        = res_reg.sum_ok;
    assign sentence_kind = res_reg.kind;
    assign computed_sum  = res_reg.sum;
    assign kept_length   = res_reg.len;

endmodule

`default_nettype wire
